>>> rtl/core/lsf_pkg.sv
// Shared types, widths and codes for the LED strip fade frame controller.
package lsf_pkg;

    localparam int IDX_W          = 6;
    localparam int MODE_W         = 4;
    localparam int CHAN_W         = 8;
    localparam int COLOR_W        = 3 * CHAN_W;
    localparam int PIX_MAX        = 64;
    localparam int NUM_PIXELS_DEF = 64;
    localparam int CMD_DEPTH_DEF  = 2;
    localparam int RES_DEPTH_DEF  = 4;

    localparam logic [MODE_W-1:0] MODE_SET_PIXEL = 4'd0;
    localparam logic [MODE_W-1:0] MODE_CLR_PIXEL = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SET_BG    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_ON        = 4'd3;
    localparam logic [MODE_W-1:0] MODE_OFF       = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SET_RANGE = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CLR_RANGE = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FLUSH     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_FADE      = 4'd8;

    typedef enum logic [3:0] {
        OP_SET_PIX,
        OP_CLR_PIX,
        OP_SET_BG,
        OP_ON,
        OP_OFF,
        OP_SET_RANGE,
        OP_CLR_RANGE,
        OP_FLUSH,
        OP_FADE
    } op_t;

    // Classified command: walk lo..hi; wr gates target edits (off-strip, empty range).
    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic               wr;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic               pixel_valid;
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
        logic               last;
    } res_t;

endpackage

>>> rtl/core/lsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsf_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/lsf_fifo.sv
// Small register FIFO with occupancy count.
module lsf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rptr_reg];
    assign count   = cnt_reg;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

>>> rtl/core/lsf_front.sv
// Front end: accepts commands, decodes mode, clamps ranges, queues work.
module lsf_front
    import lsf_pkg::*;
#(
    parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
    input  logic              push,
    output logic              full,
    input  logic [MODE_W-1:0] mode,
    input  logic [IDX_W-1:0]  first_index,
    input  logic [IDX_W-1:0]  last_index,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    input  logic              cmd_full,
    output logic              cmd_push,
    output cmd_t              cmd
);

    localparam logic [IDX_W:0]   NPIX     = (IDX_W + 1)'(NUM_PIXELS);
    localparam logic [IDX_W-1:0] LAST_PIX = IDX_W'(NUM_PIXELS - 1);

    logic             known;
    logic             in_strip;
    logic             range_ok;
    logic [IDX_W-1:0] hi_clamp;

    always_comb
    begin
        in_strip = ({1'b0, first_index} < NPIX);
        hi_clamp = ({1'b0, last_index} >= NPIX) ? LAST_PIX : last_index;
        range_ok = (first_index <= hi_clamp);

        known     = 1'b1;
        cmd.op    = OP_SET_PIX;
        cmd.lo    = '0;
        cmd.hi    = '0;
        cmd.wr    = 1'b1;
        cmd.color = {red, green, blue};

        case (mode)
            MODE_SET_PIXEL, MODE_CLR_PIXEL:
            begin
                cmd.op = (mode == MODE_SET_PIXEL) ? OP_SET_PIX : OP_CLR_PIX;
                cmd.wr = in_strip;
                if (in_strip)
                begin
                    cmd.lo = first_index;
                    cmd.hi = first_index;
                end
            end
            MODE_SET_RANGE, MODE_CLR_RANGE:
            begin
                cmd.op = (mode == MODE_SET_RANGE) ? OP_SET_RANGE : OP_CLR_RANGE;
                // empty range still walks one step for the ack, without writing
                cmd.wr = range_ok;
                if (range_ok)
                begin
                    cmd.lo = first_index;
                    cmd.hi = hi_clamp;
                end
            end
            MODE_SET_BG:
            begin
                cmd.op = OP_SET_BG;
                cmd.hi = LAST_PIX;
            end
            MODE_ON:
            begin
                cmd.op = OP_ON;
                cmd.hi = LAST_PIX;
            end
            MODE_OFF:
            begin
                cmd.op = OP_OFF;
                cmd.hi = LAST_PIX;
            end
            MODE_FLUSH:
            begin
                cmd.op = OP_FLUSH;
                cmd.hi = LAST_PIX;
            end
            MODE_FADE:
            begin
                cmd.op = OP_FADE;
                cmd.hi = LAST_PIX;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // unused modes are taken and dropped here
    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full && known;

endmodule

>>> rtl/core/lsf_back.sv
// Back end: walks the frame memories for one command and emits results.
module lsf_back
    import lsf_pkg::*;
#(
    parameter int NUM_PIXELS = NUM_PIXELS_DEF,
    parameter int RES_DEPTH  = RES_DEPTH_DEF,
    parameter int CNT_W      = $clog2(RES_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_empty,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    input  logic [CNT_W-1:0] res_cnt,
    output logic             res_push,
    output res_t             res
);

    logic               busy_reg, busy_next;
    logic               lit_reg, lit_next;
    cmd_t               cmd_reg, cmd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic               s2_vld_reg, s2_vld_next;
    logic               s2_final_reg, s2_final_next;
    logic [IDX_W-1:0]   s2_idx_reg, s2_idx_next;
    logic               tvld_q_reg, tvld_q_next;
    logic               svld_q_reg, svld_q_next;
    logic [PIX_MAX-1:0] tgt_vld_reg, tgt_vld_next;
    logic [PIX_MAX-1:0] shw_vld_reg, shw_vld_next;

    logic               load, skip, room, issue, final_now, stream;
    logic               tgt_we, shw_we;
    logic [COLOR_W-1:0] tgt_wdata, shw_wdata;
    logic [COLOR_W-1:0] tgt_rdata, shw_rdata;
    logic [COLOR_W-1:0] t_eff, s_eff;

    function automatic logic [CHAN_W-1:0] fade_chan(
        input logic [CHAN_W-1:0] cur,
        input logic [CHAN_W-1:0] goal
    );
        logic [CHAN_W-1:0] r;
        if (cur > goal)
        begin
            r = cur - 1'b1;
        end
        else if (cur < goal)
        begin
            r = cur + 1'b1;
        end
        else
        begin
            r = cur;
        end
        return r;
    endfunction

    lsf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (NUM_PIXELS),
        .ADDR_W(IDX_W)
    ) u_tgt_ram (
        .clk  (clk),
        .we   (tgt_we),
        .waddr(s2_idx_reg),
        .wdata(tgt_wdata),
        .re   (issue),
        .raddr(idx_reg),
        .rdata(tgt_rdata)
    );

    lsf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (NUM_PIXELS),
        .ADDR_W(IDX_W)
    ) u_shw_ram (
        .clk  (clk),
        .we   (shw_we),
        .waddr(s2_idx_reg),
        .wdata(shw_wdata),
        .re   (issue),
        .raddr(idx_reg),
        .rdata(shw_rdata)
    );

    // a new command loads only once the second stage is empty, which keeps reads clear of the last write
    assign load      = !busy_reg && !cmd_empty && !s2_vld_reg;
    assign cmd_pop   = load;
    assign skip      = ((cmd.op == OP_FLUSH) || (cmd.op == OP_FADE)) && !lit_reg;
    assign room      = ((CNT_W + 1)'(res_cnt) + (CNT_W + 1)'(s2_vld_reg))
                       < (CNT_W + 1)'(RES_DEPTH);
    assign issue     = busy_reg && room;
    assign final_now = (idx_reg == cmd_reg.hi);

    assign t_eff  = tvld_q_reg ? tgt_rdata : '0;
    assign s_eff  = svld_q_reg ? shw_rdata : '0;
    assign stream = (cmd_reg.op == OP_ON) || (cmd_reg.op == OP_OFF) ||
                    (cmd_reg.op == OP_FLUSH) || (cmd_reg.op == OP_FADE);

    // second stage: per-pixel update and result
    always_comb
    begin
        tgt_we    = 1'b0;
        shw_we    = 1'b0;
        tgt_wdata = cmd_reg.color;
        shw_wdata = t_eff;
        case (cmd_reg.op)
            OP_SET_PIX, OP_SET_RANGE:
            begin
                tgt_we = cmd_reg.wr;
            end
            OP_CLR_PIX, OP_CLR_RANGE:
            begin
                tgt_we    = cmd_reg.wr;
                tgt_wdata = bg_reg;
            end
            OP_SET_BG:
            begin
                tgt_we = (t_eff == bg_reg);
            end
            OP_ON, OP_FLUSH:
            begin
                shw_we = 1'b1;
            end
            OP_OFF:
            begin
                shw_we    = 1'b1;
                shw_wdata = '0;
            end
            OP_FADE:
            begin
                shw_we    = 1'b1;
                shw_wdata = {fade_chan(s_eff[23:16], t_eff[23:16]),
                             fade_chan(s_eff[15:8], t_eff[15:8]),
                             fade_chan(s_eff[7:0], t_eff[7:0])};
            end
            default:
            begin
                tgt_we = 1'b0;
            end
        endcase
        tgt_we = tgt_we && s2_vld_reg;
        shw_we = shw_we && s2_vld_reg;
    end

    always_comb
    begin
        res_push        = s2_vld_reg && (stream || s2_final_reg);
        res.pixel_valid = stream;
        res.index       = stream ? s2_idx_reg : '0;
        res.color       = stream ? shw_wdata : '0;
        res.last        = s2_final_reg;
    end

    always_comb
    begin
        busy_next     = busy_reg;
        lit_next      = lit_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        bg_next       = bg_reg;
        s2_vld_next   = 1'b0;
        s2_final_next = s2_final_reg;
        s2_idx_next   = s2_idx_reg;
        tvld_q_next   = tvld_q_reg;
        svld_q_next   = svld_q_reg;
        tgt_vld_next  = tgt_vld_reg;
        shw_vld_next  = shw_vld_reg;

        if (load)
        begin
            cmd_next  = cmd;
            idx_next  = cmd.lo;
            busy_next = !skip;
            if (cmd.op == OP_ON)
            begin
                lit_next = 1'b1;
            end
            else if (cmd.op == OP_OFF)
            begin
                lit_next = 1'b0;
            end
        end

        if (issue)
        begin
            s2_vld_next   = 1'b1;
            s2_final_next = final_now;
            s2_idx_next   = idx_reg;
            tvld_q_next   = tgt_vld_reg[idx_reg];
            svld_q_next   = shw_vld_reg[idx_reg];
            if (final_now)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (s2_vld_reg && s2_final_reg && (cmd_reg.op == OP_SET_BG))
        begin
            bg_next = cmd_reg.color;
        end
        if (tgt_we)
        begin
            tgt_vld_next[s2_idx_reg] = 1'b1;
        end
        if (shw_we)
        begin
            shw_vld_next[s2_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            lit_reg     <= 1'b0;
            bg_reg      <= '0;
            s2_vld_reg  <= 1'b0;
            tgt_vld_reg <= '0;
            shw_vld_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            lit_reg     <= lit_next;
            bg_reg      <= bg_next;
            s2_vld_reg  <= s2_vld_next;
            tgt_vld_reg <= tgt_vld_next;
            shw_vld_reg <= shw_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        s2_final_reg <= s2_final_next;
        s2_idx_reg   <= s2_idx_next;
        tvld_q_reg   <= tvld_q_next;
        svld_q_reg   <= svld_q_next;
    end

endmodule

>>> rtl/core/led_strip_fade_frame_controller.sv
// Top level of the LED strip fade frame controller.
//
//  channel   direction  handshake          transfer when
//  command   in         push / full        push && !full
//  result    out        pop / empty        pop && !empty
//
// A command transfer is decoded in the front end and lands in a two-entry
// command queue. The back end walks pixels lo..hi through both frame RAMs,
// one pixel per cycle while the result queue has room; each pixel is read,
// then updated and written in the cycle after. Pixels walked: frame commands
// (on, off, flush, fade, background) the whole strip; range commands lo..hi
// with hi clamped to the strip; pixel commands and empty ranges a single pixel.
// Flush or fade while off costs one queue slot and no back-end walk. Unused
// modes are taken at the front and never enter the queue.
// Reset clears per-pixel valid bits in flip-flops, so frames read as zero at
// once; there is no clearing pass and commands are taken right after reset.
// A full result queue pauses the pixel walk; the command queue keeps taking
// transfers until it fills, and full follows it.
module led_strip_fade_frame_controller
    import lsf_pkg::*;
#(
    parameter int NUM_PIXELS = NUM_PIXELS_DEF,
    parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
    parameter int RES_DEPTH  = RES_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [MODE_W-1:0] mode,
    input  logic [IDX_W-1:0]  first_index,
    input  logic [IDX_W-1:0]  last_index,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    output logic              empty,
    input  logic              pop,
    output logic              pixel_valid,
    output logic [IDX_W-1:0]  pixel_index,
    output logic [CHAN_W-1:0] out_red,
    output logic [CHAN_W-1:0] out_green,
    output logic [CHAN_W-1:0] out_blue,
    output logic              last
);

    localparam int CMD_W     = $bits(cmd_t);
    localparam int RES_W     = $bits(res_t);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // front end -> command queue
    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_t             cmd_in, cmd_out;
    logic [CMD_W-1:0] cmd_out_bits;

    // back end -> result queue
    logic                 res_push;
    res_t                 res_in, res_out;
    logic [RES_W-1:0]     res_out_bits;
    logic [RES_CNT_W-1:0] res_cnt;

    lsf_front #(
        .NUM_PIXELS(NUM_PIXELS)
    ) u_front (
        .push       (push),
        .full       (full),
        .mode       (mode),
        .first_index(first_index),
        .last_index (last_index),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    lsf_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (cmd_push),
        .din  (cmd_in),
        .full (cmd_full),
        .pop  (cmd_pop),
        .dout (cmd_out_bits),
        .empty(cmd_empty),
        .count()
    );

    assign cmd_out = cmd_t'(cmd_out_bits);

    lsf_back #(
        .NUM_PIXELS(NUM_PIXELS),
        .RES_DEPTH (RES_DEPTH),
        .CNT_W     (RES_CNT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_empty(cmd_empty),
        .cmd      (cmd_out),
        .cmd_pop  (cmd_pop),
        .res_cnt  (res_cnt),
        .res_push (res_push),
        .res      (res_in)
    );

    // result queue doubles as the output register stage
    lsf_fifo #(
        .WIDTH(RES_W),
        .DEPTH(RES_DEPTH),
        .CNT_W(RES_CNT_W)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .din  (res_in),
        .full (),
        .pop  (pop),
        .dout (res_out_bits),
        .empty(empty),
        .count(res_cnt)
    );

    assign res_out     = res_t'(res_out_bits);
    assign pixel_valid = res_out.pixel_valid;
    assign pixel_index = res_out.index;
    assign out_red     = res_out.color[3*CHAN_W-1:2*CHAN_W];
    assign out_green   = res_out.color[2*CHAN_W-1:CHAN_W];
    assign out_blue    = res_out.color[CHAN_W-1:0];
    assign last        = res_out.last;

endmodule
